/* rtl/core/wpr_pkg.sv */
// ---------------------------------------------------------------------------
// wpr_pkg
// Shared types, colour stops and the pseudocolour ROM of the run filler.
// ---------------------------------------------------------------------------
`default_nettype none

package wpr_pkg;

  // Queue between the front and the back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Colour stops: amplitude and RGB at each stop
  localparam int NOISE_FLOOR = 30;
  localparam int STOP_COUNT  = 8;
  localparam int StopV [STOP_COUNT] = '{30, 140, 160, 180, 200, 220, 240, 255};
  localparam int StopR [STOP_COUNT] = '{0, 0, 0, 40, 255, 255, 255, 255};
  localparam int StopG [STOP_COUNT] = '{0, 40, 255, 255, 255, 140, 30, 255};
  localparam int StopB [STOP_COUNT] = '{80, 255, 255, 20, 40, 0, 0, 255};

  typedef logic [15:0] color_rom_t [256];

  // Up to two runs closed by one pixel: one by a colour change (a), one by
  // the end of the row (b). Both sit on the same line.
  typedef struct packed {
    logic        a_valid;
    logic [6:0]  a_start;
    logic [7:0]  a_end;
    logic [15:0] a_color;
    logic        b_valid;
    logic [6:0]  b_start;
    logic [7:0]  b_end;
    logic [15:0] b_color;
    logic [7:0]  line;
  } run_pair_t;

  function automatic int clamp8(input int c);
    if (c < 0) return 0;
    if (c > 255) return 255;
    return c;
  endfunction

  // Segment spans are 110 for the first, 15 for the last and 20 otherwise
  function automatic int lerp(input int c0, input int c1, input int off,
                              input int seg);
    int d;
    int mag;
    int prod;
    int q;
    d    = c1 - c0;
    mag  = (d < 0) ? -d : d;
    prod = off * mag;
    case (seg)
      0:       q = prod / 110;
      6:       q = prod / 15;
      default: q = prod / 20;
    endcase
    return (d < 0) ? c0 - q : c0 + q;
  endfunction

  function automatic logic [15:0] pack565(input int r, input int g, input int b);
    logic [7:0] rr;
    logic [7:0] gg;
    logic [7:0] bb;
    rr = 8'(clamp8(r));
    gg = 8'(clamp8(g));
    bb = 8'(clamp8(b));
    return {rr[7:3], gg[7:2], bb[7:3]};
  endfunction

  function automatic logic [15:0] color_of(input int v);
    int seg;
    int off;
    seg = 0;
    if (v < NOISE_FLOOR) return 16'h0000;
    if (v >= StopV[STOP_COUNT-1])
      return pack565(StopR[STOP_COUNT-1], StopG[STOP_COUNT-1], StopB[STOP_COUNT-1]);
    for (int i = 0; i < STOP_COUNT - 1; i++) begin
      if (v >= StopV[i] && v < StopV[i+1]) seg = i;
    end
    off = v - StopV[seg];
    return pack565(lerp(StopR[seg], StopR[seg+1], off, seg),
                   lerp(StopG[seg], StopG[seg+1], off, seg),
                   lerp(StopB[seg], StopB[seg+1], off, seg));
  endfunction

  function automatic color_rom_t build_color_rom();
    color_rom_t rom;
    for (int v = 0; v < 256; v++) rom[v] = color_of(v);
    return rom;
  endfunction

  localparam color_rom_t COLOR_ROM = build_color_rom();

endpackage

`default_nettype wire

/* rtl/core/wpr_front.sv */
// ---------------------------------------------------------------------------
// wpr_front
// Colour lookup, run tracking and classification of each pixel.
// ---------------------------------------------------------------------------
`default_nettype none

module wpr_front #(
  parameter int ROW_PIXELS   = 128,
  parameter int SCREEN_LINES = 160
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire logic [7:0]         amplitude,
  input  wire logic [7:0]         line_y,
  output wpr_pkg::run_pair_t      pair,
  output logic                    pair_push
);

  localparam int CW = (ROW_PIXELS > 2) ? $clog2(ROW_PIXELS) : 1;
  localparam logic [CW-1:0] COL_LAST = CW'(ROW_PIXELS - 1);
  localparam logic [7:0]    ROW_END  = 8'(ROW_PIXELS);
  localparam logic [7:0]    LINE_MAX = 8'(SCREEN_LINES - 1);

  logic [CW-1:0] column;
  logic [CW-1:0] span_start;
  logic [15:0]   span_color;
  logic [7:0]    span_line;

  logic [CW-1:0] column_next;
  logic [CW-1:0] span_start_next;
  logic [15:0]   span_color_next;
  logic [7:0]    span_line_next;

  logic [15:0]   pix_color;
  logic          col_first;
  logic          col_last;
  logic [CW+7:0] a_start_w;
  logic [CW+7:0] a_end_w;
  logic [CW+7:0] b_start_w;

  always_comb begin
    pix_color       = wpr_pkg::COLOR_ROM[amplitude];
    col_first       = (column == '0);
    col_last        = (column == COL_LAST);
    span_start_next = span_start;
    span_color_next = span_color;
    span_line_next  = span_line;
    pair            = '0;

    if (col_first) begin
      span_line_next  = (32'(line_y) >= SCREEN_LINES) ? LINE_MAX : line_y;
      span_start_next = '0;
      span_color_next = pix_color;
    end else if (pix_color != span_color) begin
      pair.a_valid    = (span_color != 16'h0000);
      span_start_next = column;
      span_color_next = pix_color;
    end

    // wrap to the field widths for rows wider than the fields
    a_start_w     = {8'd0, span_start};
    a_end_w       = {8'd0, column};
    b_start_w     = {8'd0, span_start_next};
    pair.a_start  = a_start_w[6:0];
    pair.a_end    = a_end_w[7:0];
    pair.a_color  = span_color;
    pair.b_valid  = col_last && (span_color_next != 16'h0000);
    pair.b_start  = b_start_w[6:0];
    pair.b_end    = ROW_END;
    pair.b_color  = span_color_next;
    pair.line     = span_line_next;

    column_next   = col_last ? '0 : column + CW'(1);
    pair_push     = take && (pair.a_valid || pair.b_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      span_start <= '0;
      span_color <= '0;
      span_line  <= '0;
    end else if (take) begin
      column     <= column_next;
      span_start <= span_start_next;
      span_color <= span_color_next;
      span_line  <= span_line_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wpr_queue.sv */
// ---------------------------------------------------------------------------
// wpr_queue
// Short queue of closed run pairs between the front and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module wpr_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wpr_pkg::run_pair_t      push_data,
  input  wire logic               pop,
  output wpr_pkg::run_pair_t      head,
  output logic                    empty,
  output logic                    full
);

  localparam int AW = wpr_pkg::QUEUE_AW;

  wpr_pkg::run_pair_t entries [wpr_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (AW+1)'(wpr_pkg::QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      if (push && !pop)      count <= count + (AW+1)'(1);
      else if (pop && !push) count <= count - (AW+1)'(1);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wpr_back.sv */
// ---------------------------------------------------------------------------
// wpr_back
// Unpacks each queued pair into one or two fill-run transactions.
// ---------------------------------------------------------------------------
`default_nettype none

module wpr_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wpr_pkg::run_pair_t      head,
  input  wire logic               empty,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [6:0]              run_start,
  output logic [7:0]              run_end,
  output logic [7:0]              run_line,
  output logic [15:0]             run_color,
  output logic                    last
);

  // set once the colour-change run of the head entry has gone out
  logic second;
  logic show_a;
  logic done;

  always_comb begin
    show_a    = head.a_valid && !second;
    out_valid = !empty;
    run_start = show_a ? head.a_start : head.b_start;
    run_end   = show_a ? head.a_end   : head.b_end;
    run_color = show_a ? head.a_color : head.b_color;
    run_line  = head.line;
    last      = !(show_a && head.b_valid);
    done      = out_valid && out_ready;
    pop       = done && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (done) begin
      second <= !last;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/waterfall_pseudocolor_run_filler_unit.sv */
// ---------------------------------------------------------------------------
// waterfall_pseudocolor_run_filler_unit
// Maps amplitude bytes to RGB565 and emits horizontal fill runs per row.
// ---------------------------------------------------------------------------
// Pixels arrive in column order, ROW_PIXELS to a row; line_y is sampled at
// column 0 and saturated to SCREEN_LINES-1. One pixel is taken every cycle
// while the four-entry run queue has room; the colour lookup and run compare
// finish in that same cycle. Runs leave on the output channel one per cycle
// while out_ready is high, so a pixel that closes two runs (a colour change at
// the last column) sends them as two transactions in turn; the queue absorbs
// short bursts of that and any stall on the output side. Black runs are never
// emitted, and last marks the final run caused by a pixel.
`default_nettype none

module waterfall_pseudocolor_run_filler_unit #(
  parameter int ROW_PIXELS   = 128,
  parameter int SCREEN_LINES = 160
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  amplitude,
  input  wire logic [7:0]  line_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       run_start,
  output logic [7:0]       run_end,
  output logic [7:0]       run_line,
  output logic [15:0]      run_color,
  output logic             last
);

  wpr_pkg::run_pair_t pair;
  wpr_pkg::run_pair_t head;
  logic pair_push;
  logic q_empty;
  logic q_full;
  logic q_pop;
  logic take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  wpr_front #(
    .ROW_PIXELS   (ROW_PIXELS),
    .SCREEN_LINES (SCREEN_LINES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .amplitude (amplitude),
    .line_y    (line_y),
    .pair      (pair),
    .pair_push (pair_push)
  );

  wpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (pair_push),
    .push_data (pair),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  wpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .run_start (run_start),
    .run_end   (run_end),
    .run_line  (run_line),
    .run_color (run_color),
    .last      (last)
  );

endmodule

`default_nettype wire
